// File: rtl/lrup_pkg.sv
// ----------------------------------------------------------------------------
// lrup_pkg
// Shared constants and types for the LRU page replacement core.
// ----------------------------------------------------------------------------
package lrup_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_W     = 16;
    localparam int CFG_W      = 4;
    localparam int FRAME_W    = 3;
    localparam int FAULT_W    = 32;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int RANK_W     = IDX_W;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam logic [RANK_W-1:0]  RANK_MAX        = RANK_W'(MAX_FRAMES - 1);
    localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = CFG_W'(MAX_FRAMES);
    localparam logic [FAULT_W-1:0] FAULT_MAX       = {FAULT_W{1'b1}};

    // result beat: hit, frame, evicted_valid, evicted_page, fault_total
    localparam int OUT_FIELDS_W = 1 + FRAME_W + 1 + PAGE_W + FAULT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
    localparam int IN_DATA_W    = ((PAGE_W + 7) / 8) * 8;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  slot;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
    } lrup_result_t;

endpackage

// File: rtl/lru_page_replacement_core.sv
// An accepted beat is registered in page_reg, then its result in out_data_reg.
// Throughput: one page reference per cycle unless m_tready stalls; lookup,
//   victim pick and rank update all complete in the single compute stage.
// Reset: frames empty, ranks and fault total zero, frame_count = 8.
// Output register holds a result while the next reference is taken in.
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement over up to eight frames with saturating fault count.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrup_pkg::IN_DATA_W-1:0]  s_tdata,  // [15:0] page
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] hit, [3:1] frame, [4] evicted_valid, [20:5] evicted_page,
    // [52:21] fault_total, [55:53] zero
    output logic [lrup_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrup_pkg::CFG_W-1:0]      cfg_data   // frame_count
);
    import lrup_pkg::*;

    logic                  in_valid_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [FAULT_W-1:0]    fault_reg;
    logic [FAULT_W-1:0]    fault_next;
    logic [CFG_W-1:0]      frame_count_reg;
    logic                  out_free;
    logic                  advance;
    lrup_result_t          res;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    lrup_frame_table u_table
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .page        (page_reg),
        .frame_count (frame_count_reg),
        .result      (res)
    );

    always_comb
    begin
        fault_next = fault_reg;
        if (!res.hit && (fault_reg != FAULT_MAX))
            fault_next = fault_reg + FAULT_W'(1);
        out_data_next = {{OUT_PAD_W{1'b0}}, fault_next, res.evicted_page,
                         res.evicted_valid, FRAME_W'(res.slot), res.hit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            fault_reg       <= '0;
            frame_count_reg <= FRAME_COUNT_RST;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                fault_reg <= fault_next;
            if (cfg_valid && cfg_ready)
                frame_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            page_reg <= s_tdata[PAGE_W-1:0];
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/lrup_frame_table.sv
// ----------------------------------------------------------------------------
// lrup_frame_table
// Frame store with recency ranks; combinational lookup/victim pick, registered update.
// ----------------------------------------------------------------------------
module lrup_frame_table
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [lrup_pkg::PAGE_W-1:0] page,
    input  logic [lrup_pkg::CFG_W-1:0]  frame_count,
    output lrup_pkg::lrup_result_t      result
);
    import lrup_pkg::*;

    logic [PAGE_W-1:0]     page_reg  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] valid_next;
    logic [RANK_W-1:0]     rank_reg  [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_next [MAX_FRAMES];

    logic [CNT_W-1:0]      n_use;
    logic [MAX_FRAMES-1:0] in_use;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic                  found;
    logic                  have_empty;
    logic [IDX_W-1:0]      hit_slot;
    logic [IDX_W-1:0]      empty_slot;
    logic [IDX_W-1:0]      lru_slot;
    logic [RANK_W-1:0]     lru_rank;
    logic [IDX_W-1:0]      slot;
    logic [RANK_W-1:0]     ref_rank;
    logic                  evict;

    always_comb
    begin
        if (frame_count == '0)
            n_use = CNT_W'(1);
        else if (int'(frame_count) > MAX_FRAMES)
            n_use = CNT_W'(MAX_FRAMES);
        else
            n_use = CNT_W'(frame_count);

        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            in_use[i] = (i < int'(n_use));
            match[i]  = in_use[i] && valid_reg[i] && (page_reg[i] == page);
            empty[i]  = in_use[i] && !valid_reg[i];
        end

        found      = |match;
        have_empty = |empty;
        hit_slot   = '0;
        empty_slot = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_slot = IDX_W'(i);
            if (empty[i])
                empty_slot = IDX_W'(i);
        end

        // oldest frame, lowest index wins ties
        lru_slot = '0;
        lru_rank = rank_reg[0];
        for (int i = 1; i < MAX_FRAMES; i++)
        begin
            if (in_use[i] && (rank_reg[i] > lru_rank))
            begin
                lru_slot = IDX_W'(i);
                lru_rank = rank_reg[i];
            end
        end

        if (found)
            slot = hit_slot;
        else if (have_empty)
            slot = empty_slot;
        else
            slot = lru_slot;

        ref_rank = rank_reg[hit_slot];
        evict    = !found && !have_empty;

        valid_next = valid_reg;
        if (!found)
            valid_next[slot] = 1'b1;

        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (IDX_W'(i) == slot)
                rank_next[i] = '0;
            else if (in_use[i] && valid_reg[i] && (!found || (rank_reg[i] < ref_rank))
                     && (rank_reg[i] != RANK_MAX))
                rank_next[i] = rank_reg[i] + RANK_W'(1);
        end

        result.hit           = found;
        result.slot          = slot;
        result.evicted_valid = evict;
        result.evicted_page  = evict ? page_reg[slot] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
                rank_reg[i] <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !found)
            page_reg[slot] <= page;
    end

endmodule

// File: rtl/lrup_checker.sv
// ----------------------------------------------------------------------------
// lrup_checker
// Port-level checks for the LRU page replacement core.
// ----------------------------------------------------------------------------
module lrup_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lrup_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lrup_pkg::*;

    localparam int HIT_B   = 0;
    localparam int EVV_B   = 1 + FRAME_W;
    localparam int EVP_LO  = EVV_B + 1;
    localparam int FLT_LO  = EVP_LO + PAGE_W;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[HIT_B] && m_tdata[EVV_B]))
        else $error("hit reported together with eviction");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[EVV_B] |-> m_tdata[FLT_LO-1:EVP_LO] == '0)
        else $error("evicted page nonzero without eviction");

    a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[HIT_B] |-> m_tdata[FLT_LO+FAULT_W-1:FLT_LO] != '0)
        else $error("fault beat with zero fault total");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind lru_page_replacement_core lrup_checker u_lrup_checker (.*);

// File: sim/tb_lru_page_replacement_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_core
// Drives page references into the LRU core; each result beat is checked against
// an in-bench LRU predictor or a typed row's beat. A short directed table covers
// reset, fill, eviction and frame_count changes (including out-of-range counts);
// random phases follow with varying frame_count, working sets and backpressure.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_core;

    import lrup_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int WDOG_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int SEG_COUNT    = 8;
    localparam int SEG_ITEMS    = 180;
    localparam int DIR_ROWS     = 24;

    typedef struct packed {
        logic [FAULT_W-1:0] fault_total;
        logic [PAGE_W-1:0]  evicted_page;
        logic               evicted_valid;
        logic [FRAME_W-1:0] frame;
        logic               hit;
    } lru_result_t;

    typedef enum logic {ROW_PAGE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [15:0]  value;
        logic         typed;
        lru_result_t  res;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // predictor state
    logic [PAGE_W-1:0]  frm_page  [MAX_FRAMES];
    logic               frm_valid [MAX_FRAMES];
    logic [RANK_W-1:0]  frm_rank  [MAX_FRAMES];
    logic [FAULT_W-1:0] fault_cnt;
    logic [CFG_W-1:0]   frames_cfg;

    lru_result_t pending_results [$];

    int errors       = 0;
    int s_idle_pct   = 0;
    int r_idle_pct   = 0;
    int stall_ask    = 0;
    int stall_seen   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    logic [PAGE_W-1:0] ws_pages [12];
    int                ws_n;

    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{ROW_PAGE, 16'h0000, 1'b1, '{32'd1, 16'h0000, 1'b0, 3'd0, 1'b0}},
        '{ROW_PAGE, 16'hFFFF, 1'b1, '{32'd2, 16'h0000, 1'b0, 3'd1, 1'b0}},
        '{ROW_PAGE, 16'h0000, 1'b1, '{32'd2, 16'h0000, 1'b0, 3'd0, 1'b1}},
        '{ROW_PAGE, 16'hFFFF, 1'b1, '{32'd2, 16'h0000, 1'b0, 3'd1, 1'b1}},
        '{ROW_PAGE, 16'h0001, 1'b1, '{32'd3, 16'h0000, 1'b0, 3'd2, 1'b0}},
        '{ROW_PAGE, 16'h0002, 1'b1, '{32'd4, 16'h0000, 1'b0, 3'd3, 1'b0}},
        '{ROW_PAGE, 16'h0003, 1'b1, '{32'd5, 16'h0000, 1'b0, 3'd4, 1'b0}},
        '{ROW_PAGE, 16'h0004, 1'b1, '{32'd6, 16'h0000, 1'b0, 3'd5, 1'b0}},
        '{ROW_PAGE, 16'h0005, 1'b1, '{32'd7, 16'h0000, 1'b0, 3'd6, 1'b0}},
        '{ROW_PAGE, 16'h0006, 1'b1, '{32'd8, 16'h0000, 1'b0, 3'd7, 1'b0}},
        '{ROW_PAGE, 16'h8000, 1'b1, '{32'd9, 16'h0000, 1'b1, 3'd0, 1'b0}},
        '{ROW_PAGE, 16'h0000, 1'b0, '0},
        // shrink: upper frames keep their pages but are not searched
        '{ROW_CFG,  16'd2,    1'b0, '0},
        '{ROW_PAGE, 16'h0003, 1'b0, '0},
        '{ROW_PAGE, 16'h8000, 1'b0, '0},
        // zero count behaves as one frame
        '{ROW_CFG,  16'd0,    1'b0, '0},
        '{ROW_PAGE, 16'h1234, 1'b0, '0},
        '{ROW_PAGE, 16'h1234, 1'b0, '0},
        // above range behaves as eight; stale frames come back with tied ranks
        '{ROW_CFG,  16'd15,   1'b0, '0},
        '{ROW_PAGE, 16'h0004, 1'b0, '0},
        '{ROW_PAGE, 16'h0006, 1'b0, '0},
        '{ROW_PAGE, 16'hA5A5, 1'b0, '0},
        '{ROW_PAGE, 16'h5A5A, 1'b0, '0},
        '{ROW_CFG,  16'd8,    1'b0, '0}
    };

    int seg_frames [SEG_COUNT] = '{8, 1, 3, 15, 0, 6, 2, 8};

    lru_page_replacement_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // LRU lookup and update; returns the result beat the core should produce
    function automatic lru_result_t lru_lookup(input logic [PAGE_W-1:0] pg);
        int          n;
        int          slot;
        int          i;
        logic        found;
        logic        have_empty;
        logic [RANK_W-1:0] hit_rank;
        lru_result_t r;

        n = (frames_cfg == 0) ? 1 : (frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg);
        r = '0;
        found = 1'b0;
        have_empty = 1'b0;
        slot = 0;
        for (i = 0; i < n; i++)
        begin
            if (!found && frm_valid[i] && frm_page[i] == pg)
            begin
                found = 1'b1;
                slot = i;
            end
        end
        if (found)
        begin
            hit_rank = frm_rank[slot];
            for (i = 0; i < n; i++)
                if (i != slot && frm_valid[i] && frm_rank[i] < hit_rank && frm_rank[i] != RANK_MAX)
                    frm_rank[i]++;
            frm_rank[slot] = '0;
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                if (!have_empty && !frm_valid[i])
                begin
                    have_empty = 1'b1;
                    slot = i;
                end
            end
            if (!have_empty)
            begin
                slot = 0;
                for (i = 1; i < n; i++)
                    if (frm_rank[i] > frm_rank[slot])
                        slot = i;
                r.evicted_valid = 1'b1;
                r.evicted_page  = frm_page[slot];
            end
            for (i = 0; i < n; i++)
                if (i != slot && frm_valid[i] && frm_rank[i] != RANK_MAX)
                    frm_rank[i]++;
            frm_page[slot]  = pg;
            frm_valid[slot] = 1'b1;
            frm_rank[slot]  = '0;
            if (fault_cnt != FAULT_MAX)
                fault_cnt++;
        end
        r.hit         = found;
        r.frame       = FRAME_W'(slot);
        r.fault_total = fault_cnt;
        return r;
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        int sel;

        sel = $urandom_range(99);
        if (sel < 65)
            return ws_pages[$urandom_range(ws_n - 1)];
        else if (sel < 92)
            return PAGE_W'($urandom);
        else if (sel < 96)
            return '0;
        else
            return '1;
    endfunction

    task automatic new_working_set(input int frames);
        int n;
        int i;

        n = (frames == 0) ? 1 : (frames > MAX_FRAMES) ? MAX_FRAMES : frames;
        ws_n = n + $urandom_range(3);
        for (i = 0; i < ws_n; i++)
            ws_pages[i] = PAGE_W'($urandom);
    endtask

    // called at a falling edge; returns at a falling edge with the beat taken
    task automatic send_page(input logic [PAGE_W-1:0] pg, input logic typed,
                             input lru_result_t typed_res);
        lru_result_t res;

        if ($urandom_range(99) < s_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < s_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(pg);
        do @(posedge clk); while (!s_tready);
        res = lru_lookup(pg);
        pending_results.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        frames_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random tready, plus long holds on request
    always @(negedge clk)
    begin
        if (stall_ask != stall_seen)
        begin
            stall_seen = stall_ask;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= r_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        lru_result_t act;
        lru_result_t exp;

        if (rst_n && m_tvalid && m_tready)
        begin
            act = m_tdata[OUT_FIELDS_W-1:0];
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", m_tdata);
                errors++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (act.hit !== exp.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp.hit, act.hit);
                    errors++;
                end
                if (act.frame !== exp.frame)
                begin
                    $error("frame: expected %0d, got %0d", exp.frame, act.frame);
                    errors++;
                end
                if (act.evicted_valid !== exp.evicted_valid)
                begin
                    $error("evicted_valid: expected %0d, got %0d",
                           exp.evicted_valid, act.evicted_valid);
                    errors++;
                end
                if (act.evicted_page !== exp.evicted_page)
                begin
                    $error("evicted_page: expected %h, got %h",
                           exp.evicted_page, act.evicted_page);
                    errors++;
                end
                if (act.fault_total !== exp.fault_total)
                begin
                    $error("fault_total: expected %0d, got %0d",
                           exp.fault_total, act.fault_total);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
            $display("tb_lru_page_replacement_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        int row;
        int seg;
        int k;

        for (k = 0; k < MAX_FRAMES; k++)
        begin
            frm_page[k]  = '0;
            frm_valid[k] = 1'b0;
            frm_rank[k]  = '0;
        end
        fault_cnt  = '0;
        frames_cfg = FRAME_COUNT_RST;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        s_idle_pct = 33;
        r_idle_pct = 65;
        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (dir_tbl[row].kind == ROW_CFG)
                write_frames(CFG_W'(dir_tbl[row].value));
            else
                send_page(dir_tbl[row].value, dir_tbl[row].typed, dir_tbl[row].res);
        end

        for (seg = 0; seg < SEG_COUNT; seg++)
        begin
            if (seg < 3)
            begin
                s_idle_pct = 33;
                r_idle_pct = 65;
            end
            else if (seg < 6)
            begin
                s_idle_pct = 65;
                r_idle_pct = 33;
            end
            else
            begin
                s_idle_pct = 0;
                r_idle_pct = 0;
            end
            write_frames(CFG_W'(seg_frames[seg]));
            for (k = 0; k < SEG_ITEMS; k++)
            begin
                if (k % 40 == 0)
                    new_working_set(seg_frames[seg]);
                // long receiver hold while references keep coming
                if (k == 90 && (seg == 1 || seg == 6))
                    stall_ask++;
                // sender stops until the pipe is empty
                if (k == 90 && seg == 4)
                    wait_drained();
                send_page(pick_page(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_lru_page_replacement_core: done, clean");
        else
            $display("tb_lru_page_replacement_core: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/lrup_pkg.sv
rtl/lrup_frame_table.sv
rtl/lru_page_replacement_core.sv
rtl/lrup_checker.sv
sim/tb_lru_page_replacement_core.sv
